// File: hdl/fnm_pkg.sv
// Package: field widths, command and status codes, register indexes for the mailbox.
package fnm_pkg;

	localparam int CMD_W    = 2;
	localparam int HANDLE_W = 4;
	localparam int AREA_W   = 64;
	localparam int TYPE_W   = 32;
	localparam int PARAM_W  = 32;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [CMD_W-1:0] CMD_CREATE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SIGNIN   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PRESENCE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_GET_NEXT = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NONE       = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL       = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_SYSTEM_AREA_BIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIVE_AREA_BIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNIN_TYPE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_TYPE   = 2'd3;

	localparam logic [AREA_W-1:0] SYSTEM_AREA_BIT_RST = 64'd1;
	localparam logic [AREA_W-1:0] LIVE_AREA_BIT_RST   = 64'd2;
	localparam logic [TYPE_W-1:0] SIGNIN_TYPE_RST     = 32'd10;
	localparam logic [TYPE_W-1:0] PRESENCE_TYPE_RST   = 32'd65538;

	localparam logic [PARAM_W-1:0] SIGNIN_PARAM   = 32'd1;
	localparam logic [PARAM_W-1:0] PRESENCE_PARAM = 32'd0;

endpackage

// File: hdl/fnm_if.sv
// Request and response channel interfaces of the mailbox.
interface fnm_req_if;
	logic                          valid;
	logic                          ready;
	logic [fnm_pkg::CMD_W-1:0]     cmd;
	logic [fnm_pkg::HANDLE_W-1:0]  handle;
	logic [fnm_pkg::AREA_W-1:0]    area_mask;
	logic [fnm_pkg::TYPE_W-1:0]    type_filter;

	modport source (output valid, cmd, handle, area_mask, type_filter, input ready);
	modport sink (input valid, cmd, handle, area_mask, type_filter, output ready);
endinterface

interface fnm_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [fnm_pkg::STATUS_W-1:0]  status;
	logic [fnm_pkg::HANDLE_W-1:0]  new_handle;
	logic [fnm_pkg::TYPE_W-1:0]    event_type;
	logic [fnm_pkg::PARAM_W-1:0]   event_param;

	modport source (output valid, status, new_handle, event_type, event_param, input ready);
	modport sink (input valid, status, new_handle, event_type, event_param, output ready);
endinterface

// File: hdl/fnm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fnm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/filtered_notification_mailbox.sv
// Filtered notification mailbox: listener table, per-listener event queues, scan sequencer.
// Create, and get next with a bad handle, go straight to the response. Sign-in/presence: a
// read and a check state per listener, no result. Get next: listener read, fill load, search,
// then on a hit gap-close and fill write-back; search and shift move one entry per cycle.
// Not ready while a request is being worked on; a stalled response holds the block.
// Reset clears listener count, config registers and control; RAMs are not cleared (no sweep).
module filtered_notification_mailbox #(
	parameter int MAX_LISTENERS = 8,
	parameter int QUEUE_DEPTH   = 128
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fnm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fnm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	fnm_req_if.sink                            req,
	fnm_rsp_if.source                          rsp
);

	localparam int HW  = fnm_pkg::HANDLE_W;
	localparam int AW  = fnm_pkg::AREA_W;
	localparam int TW  = fnm_pkg::TYPE_W;
	localparam int PW  = fnm_pkg::PARAM_W;
	localparam int SW  = fnm_pkg::STATUS_W;
	localparam int LW  = (MAX_LISTENERS > 1) ? $clog2(MAX_LISTENERS) : 1;
	localparam int CW  = $clog2(MAX_LISTENERS + 1);
	localparam int HCW = (CW > HW) ? CW : HW;
	localparam int FW  = $clog2(QUEUE_DEPTH + 1);
	localparam int QN  = MAX_LISTENERS * QUEUE_DEPTH;
	localparam int QA  = (QN > 1) ? $clog2(QN) : 1;
	localparam int LSTW = AW + FW;
	localparam int QW   = TW + PW;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BRD,
		S_BCHK,
		S_GLST,
		S_GFILL,
		S_SRCH,
		S_SHIFT,
		S_GDONE,
		S_RESP
	} state_t;

	state_t         state_q;
	logic [AW-1:0]  sys_bit_q, live_bit_q;
	logic [TW-1:0]  signin_type_q, presence_type_q;
	logic [CW-1:0]  lst_cnt_q;
	logic [CW-1:0]  idx_q;
	logic [LW-1:0]  li_q;
	logic [QA-1:0]  base_q;
	logic [AW-1:0]  sel_bit_q;
	logic [TW-1:0]  ev_type_q;
	logic [PW-1:0]  ev_param_q;
	logic [AW-1:0]  area_q;
	logic [FW-1:0]  fill_q;
	logic [TW-1:0]  filter_q;
	logic [FW-1:0]  k_q;
	logic [FW-1:0]  idx_s1;
	logic           valid_s1;
	logic [SW-1:0]  res_status_q;
	logic [HW-1:0]  res_handle_q;
	logic [TW-1:0]  res_type_q;
	logic [PW-1:0]  res_param_q;
	logic           rsp_valid_q;
	logic [SW-1:0]  rsp_status_q;
	logic [HW-1:0]  rsp_handle_q;
	logic [TW-1:0]  rsp_type_q;
	logic [PW-1:0]  rsp_param_q;

	logic            lst_we;
	logic [LW-1:0]   lst_waddr, lst_raddr;
	logic [LSTW-1:0] lst_wdata, lst_rdata;
	logic            q_we;
	logic [QA-1:0]   q_waddr, q_raddr;
	logic [QW-1:0]   q_wdata, q_rdata;

	logic [AW-1:0]   rd_area;
	logic [FW-1:0]   rd_fill;
	logic [TW-1:0]   rd_type;
	logic [PW-1:0]   rd_param;
	logic [HCW-1:0]  hx;
	logic [HCW-1:0]  hx_m1;
	logic            bad_handle;
	logic            accept;
	logic            k_more;
	logic            hit;

	assign rd_area  = lst_rdata[LSTW-1:FW];
	assign rd_fill  = lst_rdata[FW-1:0];
	assign rd_type  = q_rdata[QW-1:PW];
	assign rd_param = q_rdata[PW-1:0];

	assign hx    = HCW'(req.handle);
	assign hx_m1 = hx - HCW'(1);
	assign bad_handle = (hx == '0) || (hx > HCW'(lst_cnt_q)) || (hx > HCW'(MAX_LISTENERS));

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign k_more    = (k_q < fill_q);
	assign hit       = valid_s1 && ((filter_q == '0) || (rd_type == filter_q));

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.new_handle  = rsp_handle_q;
	assign rsp.event_type  = rsp_type_q;
	assign rsp.event_param = rsp_param_q;

	fnm_ram #(.WIDTH(LSTW), .DEPTH(MAX_LISTENERS)) u_lst_ram (
		.clk   (clk),
		.we    (lst_we),
		.waddr (lst_waddr),
		.wdata (lst_wdata),
		.raddr (lst_raddr),
		.rdata (lst_rdata)
	);

	fnm_ram #(.WIDTH(QW), .DEPTH(QN)) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	always_comb begin
		lst_we    = 1'b0;
		lst_waddr = idx_q[LW-1:0];
		lst_wdata = {rd_area, rd_fill + FW'(1)};
		lst_raddr = idx_q[LW-1:0];
		q_we      = 1'b0;
		q_waddr   = base_q + QA'(rd_fill);
		q_wdata   = {ev_type_q, ev_param_q};
		q_raddr   = base_q + QA'(k_q);
		unique case (state_q)
			S_IDLE: begin
				lst_waddr = lst_cnt_q[LW-1:0];
				lst_wdata = {req.area_mask, FW'(0)};
				lst_we    = accept && (req.cmd == fnm_pkg::CMD_CREATE)
					&& (lst_cnt_q < CW'(MAX_LISTENERS));
			end
			S_BCHK: begin
				if (((rd_area & sel_bit_q) != '0) && (rd_fill < FW'(QUEUE_DEPTH))) begin
					lst_we = 1'b1;
					q_we   = 1'b1;
				end
			end
			S_GLST: begin
				lst_raddr = li_q;
			end
			S_SHIFT: begin
				q_we    = valid_s1;
				q_waddr = base_q + QA'(idx_s1) - QA'(1);
				q_wdata = q_rdata;
			end
			S_GDONE: begin
				lst_we    = 1'b1;
				lst_waddr = li_q;
				lst_wdata = {area_q, fill_q - FW'(1)};
			end
			S_BRD, S_GFILL, S_SRCH, S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			sys_bit_q       <= fnm_pkg::SYSTEM_AREA_BIT_RST;
			live_bit_q      <= fnm_pkg::LIVE_AREA_BIT_RST;
			signin_type_q   <= fnm_pkg::SIGNIN_TYPE_RST;
			presence_type_q <= fnm_pkg::PRESENCE_TYPE_RST;
			lst_cnt_q       <= '0;
			idx_q           <= '0;
			k_q             <= '0;
			valid_s1        <= 1'b0;
			rsp_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					fnm_pkg::REG_SYSTEM_AREA_BIT: sys_bit_q <= cfg_wdata;
					fnm_pkg::REG_LIVE_AREA_BIT:   live_bit_q <= cfg_wdata;
					fnm_pkg::REG_SIGNIN_TYPE:     signin_type_q <= cfg_wdata[TW-1:0];
					fnm_pkg::REG_PRESENCE_TYPE:   presence_type_q <= cfg_wdata[TW-1:0];
					default: begin
					end
				endcase
			end

			if (rsp_valid_q && rsp.ready && (state_q != S_RESP)) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_status_q <= fnm_pkg::ST_OK;
						res_handle_q <= '0;
						res_type_q   <= '0;
						res_param_q  <= '0;
						idx_q        <= '0;
						unique case (req.cmd)
							fnm_pkg::CMD_CREATE: begin
								if (lst_cnt_q < CW'(MAX_LISTENERS)) begin
									lst_cnt_q    <= lst_cnt_q + CW'(1);
									res_handle_q <= HW'(lst_cnt_q + CW'(1));
								end else begin
									res_status_q <= fnm_pkg::ST_FULL;
								end
								state_q <= S_RESP;
							end
							fnm_pkg::CMD_SIGNIN: begin
								sel_bit_q  <= sys_bit_q;
								ev_type_q  <= signin_type_q;
								ev_param_q <= fnm_pkg::SIGNIN_PARAM;
								state_q    <= S_BRD;
							end
							fnm_pkg::CMD_PRESENCE: begin
								sel_bit_q  <= live_bit_q;
								ev_type_q  <= presence_type_q;
								ev_param_q <= fnm_pkg::PRESENCE_PARAM;
								state_q    <= S_BRD;
							end
							fnm_pkg::CMD_GET_NEXT: begin
								filter_q <= req.type_filter;
								li_q     <= hx_m1[LW-1:0];
								if (bad_handle) begin
									res_status_q <= fnm_pkg::ST_BAD_HANDLE;
									state_q      <= S_RESP;
								end else begin
									state_q <= S_GLST;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_BRD: begin
					if (idx_q < lst_cnt_q) begin
						base_q  <= QA'(idx_q[LW-1:0]) * QA'(QUEUE_DEPTH);
						state_q <= S_BCHK;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_BCHK: begin
					idx_q   <= idx_q + CW'(1);
					state_q <= S_BRD;
				end
				S_GLST: begin
					base_q  <= QA'(li_q) * QA'(QUEUE_DEPTH);
					state_q <= S_GFILL;
				end
				S_GFILL: begin
					area_q   <= rd_area;
					fill_q   <= rd_fill;
					k_q      <= '0;
					valid_s1 <= 1'b0;
					state_q  <= S_SRCH;
				end
				S_SRCH: begin
					if (hit) begin
						res_type_q  <= rd_type;
						res_param_q <= rd_param;
						k_q         <= idx_s1 + FW'(1);
						valid_s1    <= 1'b0;
						state_q     <= S_SHIFT;
					end else if (!valid_s1 && !k_more) begin
						res_status_q <= fnm_pkg::ST_NONE;
						state_q      <= S_RESP;
					end else begin
						valid_s1 <= k_more;
						idx_s1   <= k_q;
						if (k_more) begin
							k_q <= k_q + FW'(1);
						end
					end
				end
				S_SHIFT: begin
					if (!valid_s1 && !k_more) begin
						state_q <= S_GDONE;
					end else begin
						valid_s1 <= k_more;
						idx_s1   <= k_q;
						if (k_more) begin
							k_q <= k_q + FW'(1);
						end
					end
				end
				S_GDONE: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_handle_q <= res_handle_q;
						rsp_type_q   <= res_type_q;
						rsp_param_q  <= res_param_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
